// File: hw/rtl/tsgs_pkg.sv
// Shared types, constants and helpers for the touch-strip gate smoother.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package tsgs_pkg;

	// Depth of the ring of recent smoothed values.
	localparam int HIST_DEPTH = 16;
	localparam int RING_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

	// Field widths.
	localparam int SAMPLE_W = 14;
	localparam int VALUE_W  = 24;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 24;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] CFG_PRESS_THRESHOLD = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_HOLD_TICKS      = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_MAX_JUMP_DELTA  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_BLEND_WEIGHT    = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_SCALE_GAIN      = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_SCALE_OFFSET    = 3'd5;

	// Event codes reported with each result.
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_UPDATE  = 2'd3
	} ev_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [13:0]        press_threshold;
		logic [7:0]         hold_ticks;
		logic [13:0]        max_jump_delta;
		logic [16:0]        blend_weight;
		logic [15:0]        scale_gain;
		logic signed [23:0] scale_offset;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic decide;
		logic scale;
		logic apply;
		logic fill;
		logic bmul;
		logic badd;
		logic write;
		logic load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		ev_t  ev;
		logic jump;
		logic fill_last;
	} dp_status_t;

	// Next ring position, wrapping at the ring depth.
	function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
		if (p == RING_AW'(HIST_DEPTH - 1)) begin
			return '0;
		end
		return p + RING_AW'(1);
	endfunction

endpackage

// File: hw/rtl/tsgs_ram.sv
// Generic single-port RAM with registered read data.
// Self-contained; used by the datapath for the value ring.
`timescale 1ns / 1ps

module tsgs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port share one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/tsgs_ctrl.sv
// Controller state machine for the touch-strip gate smoother.
// Depends on tsgs_pkg; drives the datapath commands and the channel handshakes.
`timescale 1ns / 1ps

module tsgs_ctrl
	import tsgs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_MUL    = 9'b000000010,
		S_SCALE  = 9'b000000100,
		S_APPLY  = 9'b000001000,
		S_FILL   = 9'b000010000,
		S_BMUL   = 9'b000100000,
		S_BADD   = 9'b001000000,
		S_WRITE  = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load_ok;

	// The result register may be reloaded once it is empty or being taken.
	assign load_ok  = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.decide = 1'b1;
				state_d    = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				case (status.ev)
					EV_PRESS:  state_d = S_FILL;
					EV_UPDATE: state_d = status.jump ? S_WRITE : S_BMUL;
					default:   state_d = S_FINISH;
				endcase
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (status.fill_last) begin
					state_d = S_FINISH;
				end
			end
			S_BMUL: begin
				cmd.bmul = 1'b1;
				state_d  = S_BADD;
			end
			S_BADD: begin
				cmd.badd = 1'b1;
				state_d  = S_WRITE;
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (load_ok) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A new result appears only after the finishing step.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result became valid outside the finishing step");

	// The ring fill ends exactly on its last entry.
	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL && status.fill_last) |=> (state_q == S_FINISH))
		else $error("ring fill did not end after its last entry");

	// An accepted transaction always starts the multiply step.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_MUL))
		else $error("accepted transaction did not start processing");

endmodule

// File: hw/rtl/tsgs_datapath.sv
// Datapath of the touch-strip gate smoother: gate state, scaling, blending
// and the value ring. Depends on tsgs_pkg and tsgs_ram.
`timescale 1ns / 1ps

module tsgs_datapath
	import tsgs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	input  logic [SAMPLE_W-1:0]       sample,
	output logic signed [VALUE_W-1:0] smoothed_value,
	output logic [1:0]                event_res,
	output logic                      gate_open
);

	localparam logic signed [26:0] S24_MAX = 27'sd8388607;
	localparam logic signed [26:0] S24_MIN = -27'sd8388608;

	function automatic logic signed [VALUE_W-1:0] sat24(input logic signed [26:0] v);
		if (v > S24_MAX) begin
			return 24'sh7FFFFF;
		end
		if (v < S24_MIN) begin
			return 24'sh800000;
		end
		return v[VALUE_W-1:0];
	endfunction

	// Block state.
	logic                      gate_q;
	logic [7:0]                cd_q;
	logic [SAMPLE_W-1:0]       last_q;
	logic signed [VALUE_W-1:0] smooth_q;
	logic [RING_AW-1:0]        pos_q;

	// Working registers of one transaction.
	logic [SAMPLE_W-1:0]       sample_q;
	ev_t                       ev_q;
	logic                      jump_q;
	logic [29:0]               prod_s1;
	logic signed [VALUE_W-1:0] scaled_q;
	logic signed [42:0]        blend_s1;
	logic [RING_AW-1:0]        fill_cnt_q;

	// Result register.
	logic signed [VALUE_W-1:0] out_value_q;
	ev_t                       out_ev_q;
	logic                      out_gate_q;

	// Ring memory port.
	logic                      ram_we;
	logic                      ram_re;
	logic [RING_AW-1:0]        ram_addr;
	logic [VALUE_W-1:0]        ram_wdata;
	logic [VALUE_W-1:0]        ram_rdata;

	logic [RING_AW-1:0]        pos_next;
	logic [7:0]                cd_dec;
	logic                      pressed;
	logic                      press_now;
	logic                      release_now;
	logic [SAMPLE_W-1:0]       delta;
	logic signed [26:0]        scale_sum;
	logic signed [24:0]        diff;
	logic signed [26:0]        blend_sum;

	// Decision of what this sample does to the gate.
	always_comb begin
		pos_next    = ring_next(pos_q);
		cd_dec      = (cd_q != 8'd0) ? cd_q - 8'd1 : 8'd0;
		pressed     = sample_q > cfg.press_threshold;
		press_now   = pressed && (last_q < cfg.press_threshold) && !gate_q;
		release_now = !press_now && !pressed && gate_q && (cd_dec == 8'd0);
		delta       = (sample_q > last_q) ? sample_q - last_q : last_q - sample_q;
	end

	// Scaling sum and blend arithmetic.
	always_comb begin
		scale_sum = $signed({5'b0, prod_s1[29:8]}) + 27'(cfg.scale_offset);
		diff      = 25'(scaled_q) - 25'(smooth_q);
		blend_sum = 27'(smooth_q) + blend_s1[42:16];
	end

	// Ring port: read the oldest entry while deciding, write on fill or update.
	always_comb begin
		ram_re    = cmd.decide;
		ram_we    = cmd.fill || cmd.write;
		ram_addr  = cmd.fill ? fill_cnt_q : pos_next;
		ram_wdata = cmd.fill ? scaled_q : smooth_q;
	end

	tsgs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(HIST_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Per-transaction working registers.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			sample_q <= sample;
		end
		if (cmd.decide) begin
			prod_s1 <= 30'(sample_q) * 30'(cfg.scale_gain);
			jump_q  <= delta > cfg.max_jump_delta;
			if (press_now) begin
				ev_q <= EV_PRESS;
			end else if (release_now) begin
				ev_q <= EV_RELEASE;
			end else if (pressed) begin
				ev_q <= EV_UPDATE;
			end else begin
				ev_q <= EV_NONE;
			end
		end
		if (cmd.scale) begin
			scaled_q <= sat24(scale_sum);
		end
		if (cmd.bmul) begin
			blend_s1 <= 43'(diff) * 43'($signed({1'b0, cfg.blend_weight}));
		end
		if (cmd.apply) begin
			fill_cnt_q <= '0;
		end else if (cmd.fill) begin
			fill_cnt_q <= fill_cnt_q + RING_AW'(1);
		end
		if (cmd.load_out) begin
			out_value_q <= smooth_q;
			out_ev_q    <= ev_q;
			out_gate_q  <= gate_q;
		end
	end

	// Block state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q   <= 1'b0;
			cd_q     <= 8'd0;
			last_q   <= '0;
			smooth_q <= '0;
			pos_q    <= '0;
		end else begin
			if (cmd.apply) begin
				cd_q   <= (ev_q == EV_PRESS) ? cfg.hold_ticks : cd_dec;
				last_q <= sample_q;
				case (ev_q)
					EV_PRESS: begin
						gate_q   <= 1'b1;
						smooth_q <= scaled_q;
					end
					EV_RELEASE: begin
						gate_q   <= 1'b0;
						smooth_q <= $signed(ram_rdata);
					end
					EV_UPDATE: begin
						if (jump_q) begin
							smooth_q <= scaled_q;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.badd) begin
				smooth_q <= sat24(blend_sum);
			end
			if (cmd.write) begin
				pos_q <= pos_next;
			end
		end
	end

	assign status.ev        = ev_q;
	assign status.jump      = jump_q;
	assign status.fill_last = (fill_cnt_q == RING_AW'(HIST_DEPTH - 1));

	assign smoothed_value = out_value_q;
	assign event_res      = out_ev_q;
	assign gate_open      = out_gate_q;

	// The countdown only runs while the gate is open.
	a_cd_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(cd_q != 8'd0) |-> gate_q)
		else $error("gate countdown running with the gate closed");

	// The gate closes only through a release.
	a_gate_close: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(gate_q) |-> $past(cmd.apply && ev_q == EV_RELEASE))
		else $error("gate closed without a release");

endmodule

// File: hw/rtl/touch_strip_gate_smoother_top.sv
// Top level of the touch-strip gate smoother: configuration registers and the
// controller and datapath instances. Depends on tsgs_pkg, tsgs_ctrl, tsgs_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready, sample) takes one raw strip reading per
//   transaction. Output channel (out_valid/out_ready) returns exactly one result
//   per input: smoothed_value, event_res (none, press, release, update) and
//   gate_open. Configuration writes use cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high and indexes beyond the list are ignored.
//   Write configuration only while the block is idle.
// Processing steps:
//   The controller steps through multiply, scale and apply, then a ring write
//   for a jump update, blend multiply, add and ring write for a smoothed
//   update, or a fill of all HIST_DEPTH ring entries on a press; no event and a
//   release go straight to the finishing step, which loads the result register.
//   The controller then returns to idle and can take the next input, so one
//   input is in flight at a time.
// Reset and stalls:
//   Reset closes the gate, clears the countdown, last sample, smoothed value
//   and ring position, and loads register defaults. A stalled receiver holds
//   the result; one more input is processed and then waits for the output.
`timescale 1ns / 1ps

module touch_strip_gate_smoother_top
	import tsgs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SAMPLE_W-1:0]       sample,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] smoothed_value,
	output logic [1:0]                event_res,
	output logic                      gate_open,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IW-1:0]         cfg_index,
	input  logic [CFG_DW-1:0]         cfg_data
);

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_threshold <= 14'd512;
			cfg_q.hold_ticks      <= 8'd10;
			cfg_q.max_jump_delta  <= 14'd64;
			cfg_q.blend_weight    <= 17'd16384;
			cfg_q.scale_gain      <= 16'd256;
			cfg_q.scale_offset    <= 24'sd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PRESS_THRESHOLD: cfg_q.press_threshold <= cfg_data[13:0];
				CFG_HOLD_TICKS:      cfg_q.hold_ticks      <= cfg_data[7:0];
				CFG_MAX_JUMP_DELTA:  cfg_q.max_jump_delta  <= cfg_data[13:0];
				CFG_BLEND_WEIGHT:    cfg_q.blend_weight    <= cfg_data[16:0];
				CFG_SCALE_GAIN:      cfg_q.scale_gain      <= cfg_data[15:0];
				CFG_SCALE_OFFSET:    cfg_q.scale_offset    <= $signed(cfg_data[23:0]);
				default: begin
				end
			endcase
		end
	end

	tsgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tsgs_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.status        (status),
		.sample        (sample),
		.smoothed_value(smoothed_value),
		.event_res     (event_res),
		.gate_open     (gate_open)
	);

endmodule
